### rtl/bft_pkg.sv
// Package for the tape data path: field widths, operation codes and the result word type.
`timescale 1ns / 1ps
package bft_pkg;

    localparam int OP_W   = 4;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;

    // Instruction codes as delivered by the sequencer
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_LEFT  = 4'd2,
        OP_RIGHT = 4'd3,
        OP_OPEN  = 4'd4,
        OP_CLOSE = 4'd5,
        OP_OUT   = 4'd6,
        OP_IN    = 4'd7,
        OP_CLEAR = 4'd8,
        OP_NOP   = 4'd9
    } t_op;

    // One result word
    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              jump_taken;
        logic              fault;
    } t_rsp;

endpackage

### rtl/bft_if.sv
// Handshake channel interfaces for instruction words and result words.
`timescale 1ns / 1ps
interface bft_req_if import bft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   req_type;
    logic [CNT_W-1:0]  repeat_count;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output req_type, output repeat_count, output in_byte,
                    input ready);
    modport sink   (input valid, input req_type, input repeat_count, input in_byte,
                    output ready);
endinterface

interface bft_rsp_if import bft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              jump_taken;
    logic              fault;

    modport source (output valid, output out_valid, output out_byte, output jump_taken,
                    output fault, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input jump_taken,
                    input fault, output ready);
endinterface

### rtl/bft_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bf_tape_datapath_core.sv
// Top level: tape memory, data pointer, read-modify-write stage and result queue.
// Path: an accepted word is registered into stage 1, and its result then into the result queue.
// Throughput: one word per cycle while the result queue has room, set by the single
// read-modify-write pass on the tape RAM (one read and one write port, previous-write forwarding).
// Reset: pointer and halt flag clear at once; then a clearing pass writes zero to all
// TAPE_CELLS tape cells, one per cycle, and no word is accepted until it finishes.
`timescale 1ns / 1ps
module bf_tape_datapath_core import bft_pkg::*; #(
    parameter int TAPE_CELLS = 32768
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bft_req_if.sink  i_req,
    bft_rsp_if.source o_rsp
);

    localparam int PTR_W   = $clog2(TAPE_CELLS);
    localparam int SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int Q_DEPTH = 3;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_clr_addr;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic              r_halted, n_halted;

    // Stage 1 (cell read back from RAM)
    logic              r_s1_vld;
    t_op               r_s1_op, n_s1_op;
    logic [BYTE_W-1:0] r_s1_cnt;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [PTR_W-1:0]  r_s1_addr;
    logic              r_s1_fault, n_s1_fault;

    // Last write, forwarded to the following word
    logic              r_fwd_vld;
    logic [PTR_W-1:0]  r_fwd_addr;
    logic [BYTE_W-1:0] r_fwd_data;

    // Result queue
    t_rsp              r_q_data [Q_DEPTH];
    logic [1:0]        r_q_head, r_q_tail;
    logic [1:0]        r_q_cnt;

    logic              accept, pop;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;
    logic [BYTE_W-1:0] cur_byte, new_cell;
    logic              cell_we;
    t_rsp              s1_rsp;
    logic [SUM_W-1:0]  p_ext, c_ext, sum_ext, dif_ext;

    assign i_req.ready = (r_state == ST_RUN) &&
                         ((3'(r_q_cnt) + 3'(r_s1_vld)) <= 3'(Q_DEPTH - 1));
    assign accept      = i_req.valid && i_req.ready;
    assign pop         = o_rsp.valid && o_rsp.ready;

    // Pointer update and fault detection at accept
    assign p_ext   = SUM_W'(r_ptr);
    assign c_ext   = SUM_W'(i_req.repeat_count);
    assign sum_ext = p_ext + c_ext;
    assign dif_ext = p_ext - c_ext;

    always_comb begin
        n_ptr      = r_ptr;
        n_halted   = r_halted;
        n_s1_op    = OP_NOP;
        n_s1_fault = 1'b0;
        if (r_halted) begin
            n_s1_fault = 1'b1;
        end else begin
            case (t_op'(i_req.req_type))
                OP_ADD:   n_s1_op = OP_ADD;
                OP_SUB:   n_s1_op = OP_SUB;
                OP_LEFT: begin
                    if (c_ext > p_ext) begin
                        n_halted   = 1'b1;
                        n_s1_fault = 1'b1;
                    end else begin
                        n_ptr = dif_ext[PTR_W-1:0];
                    end
                end
                OP_RIGHT: begin
                    if (sum_ext >= SUM_W'(TAPE_CELLS)) begin
                        n_halted   = 1'b1;
                        n_s1_fault = 1'b1;
                    end else begin
                        n_ptr = sum_ext[PTR_W-1:0];
                    end
                end
                OP_OPEN:  n_s1_op = OP_OPEN;
                OP_CLOSE: n_s1_op = OP_CLOSE;
                OP_OUT:   n_s1_op = OP_OUT;
                OP_IN:    n_s1_op = OP_IN;
                OP_CLEAR: n_s1_op = OP_CLEAR;
                default:  n_s1_op = OP_NOP;
            endcase
        end
    end

    // Clearing pass sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == PTR_W'(TAPE_CELLS - 1)) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ptr      <= '0;
            r_halted   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + PTR_W'(1);
            end
            if (accept) begin
                r_ptr    <= n_ptr;
                r_halted <= n_halted;
            end
            r_s1_vld  <= accept;
            r_fwd_vld <= r_s1_vld && cell_we;
        end
    end

    // Stage 1 payload; RAM read address is the pointer before update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op    <= n_s1_op;
            r_s1_cnt   <= i_req.repeat_count[BYTE_W-1:0];
            r_s1_byte  <= i_req.in_byte;
            r_s1_addr  <= r_ptr;
            r_s1_fault <= n_s1_fault;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= new_cell;
    end

    // Tape RAM
    bft_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // Modify step with forwarding of the previous cycle's write
    assign cur_byte = (r_fwd_vld && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : ram_rdata;

    always_comb begin
        new_cell = cur_byte;
        cell_we  = 1'b0;
        s1_rsp   = '0;
        s1_rsp.fault = r_s1_fault;
        case (r_s1_op)
            OP_ADD: begin
                new_cell = cur_byte + r_s1_cnt;
                cell_we  = 1'b1;
            end
            OP_SUB: begin
                new_cell = cur_byte - r_s1_cnt;
                cell_we  = 1'b1;
            end
            OP_IN: begin
                new_cell = r_s1_byte;
                cell_we  = 1'b1;
            end
            OP_CLEAR: begin
                new_cell = '0;
                cell_we  = 1'b1;
            end
            OP_OPEN:  s1_rsp.jump_taken = (cur_byte == '0);
            OP_CLOSE: s1_rsp.jump_taken = (cur_byte != '0);
            OP_OUT: begin
                s1_rsp.out_valid = 1'b1;
                s1_rsp.out_byte  = cur_byte;
            end
            default: ;
        endcase
    end

    // Write port: clearing pass or stage 1 write-back
    assign ram_we    = (r_state == ST_CLEAR) || (r_s1_vld && cell_we);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_s1_addr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : new_cell;

    // Result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head <= '0;
            r_q_tail <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (r_s1_vld) begin
                r_q_tail <= (r_q_tail == 2'(Q_DEPTH - 1)) ? '0 : r_q_tail + 2'd1;
            end
            if (pop) begin
                r_q_head <= (r_q_head == 2'(Q_DEPTH - 1)) ? '0 : r_q_head + 2'd1;
            end
            r_q_cnt <= r_q_cnt + 2'(r_s1_vld) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_q_data[r_q_tail] <= s1_rsp;
        end
    end

    assign o_rsp.valid      = (r_q_cnt != '0);
    assign o_rsp.out_valid  = r_q_data[r_q_head].out_valid;
    assign o_rsp.out_byte   = r_q_data[r_q_head].out_byte;
    assign o_rsp.jump_taken = r_q_data[r_q_head].jump_taken;
    assign o_rsp.fault      = r_q_data[r_q_head].fault;

`ifndef SYNTH
    // No word enters while the tape is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !accept)
        else $error("word accepted during clearing pass");

    // Queue never overflows
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_vld && (r_q_cnt == 2'(Q_DEPTH)) && !pop))
        else $error("result queue overflow");

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped");

    // A word taken while halted reports a fault
    a_halted_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_halted) |=> (r_s1_vld && r_s1_fault && !cell_we))
        else $error("halted word not faulted");

    // Pointer stays on the tape
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_ptr) < SUM_W'(TAPE_CELLS))
        else $error("data pointer off the tape");
`endif

endmodule

### test/bft_tape_checker.sv
// Checker for the tape data path: shadow tape, expected result words and field compare.
`timescale 1ns / 1ps
module bft_tape_checker import bft_pkg::*; #(
    parameter int TAPE_CELLS = 32768
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bft_req_if   i_req,
    bft_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count
);

    // Shadow machine state
    logic [BYTE_W-1:0] cells [TAPE_CELLS];
    int unsigned       cur_cell;
    bit                halted;

    // Result words still owed by the block, oldest first
    t_rsp              owed_q [$];
    int                fails;
    int                checked;

    // Run one instruction word on the shadow tape and return its result word
    function automatic t_rsp execute_word(logic [OP_W-1:0] code, logic [CNT_W-1:0] cnt,
                                          logic [BYTE_W-1:0] data);
        t_rsp r;
        r = '0;
        if (halted) begin
            r.fault = 1'b1;
            return r;
        end
        case (code)
            OP_ADD:   cells[cur_cell] = cells[cur_cell] + cnt[BYTE_W-1:0];
            OP_SUB:   cells[cur_cell] = cells[cur_cell] - cnt[BYTE_W-1:0];
            OP_LEFT: begin
                if (cnt > cur_cell) begin
                    halted  = 1'b1;
                    r.fault = 1'b1;
                end else begin
                    cur_cell = cur_cell - cnt;
                end
            end
            OP_RIGHT: begin
                if (cur_cell + cnt >= TAPE_CELLS) begin
                    halted  = 1'b1;
                    r.fault = 1'b1;
                end else begin
                    cur_cell = cur_cell + cnt;
                end
            end
            OP_OPEN:  r.jump_taken = (cells[cur_cell] == '0);
            OP_CLOSE: r.jump_taken = (cells[cur_cell] != '0);
            OP_OUT: begin
                r.out_valid = 1'b1;
                r.out_byte  = cells[cur_cell];
            end
            OP_IN:    cells[cur_cell] = data;
            OP_CLEAR: cells[cur_cell] = '0;
            default: ;  // nop and unused codes
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    // Watch both channels; results are matched before new words are queued
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            foreach (cells[k]) cells[k] = '0;
            cur_cell = 0;
            halted   = 1'b0;
            owed_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_q.size() == 0) begin
                    $error("result word with no expected result waiting");
                    fails++;
                end else begin
                    want = owed_q.pop_front();
                    checked++;
                    check_field("out_valid", want.out_valid, i_rsp.out_valid);
                    check_field("out_byte", want.out_byte, i_rsp.out_byte);
                    check_field("jump_taken", want.jump_taken, i_rsp.jump_taken);
                    check_field("fault", want.fault, i_rsp.fault);
                end
            end
            if (i_req.valid && i_req.ready)
                owed_q = {owed_q, execute_word(i_req.req_type, i_req.repeat_count,
                                               i_req.in_byte)};
        end
        o_pending      <= owed_q.size();
        o_fail_count   <= fails;
        o_result_count <= checked;
    end

endmodule

### test/tb_bf_tape_datapath_core.sv
// Testbench top for the tape data path: clock, reset, instruction stimulus and verdict.
`timescale 1ns / 1ps
module tb_bf_tape_datapath_core;
    import bft_pkg::*;

    localparam int               TAPE_CELLS   = 32768;
    localparam int               RANDOM_WORDS = 780;
    localparam int               HALT_WORDS   = 12;
    localparam logic [OP_W-1:0]  LAST_CODE    = '1;

    logic  i_clk;
    logic  i_rst_n;
    bit    calm;
    int    stall_left;
    int    fail_count;
    int    pending;
    int    results_checked;
    int    words_sent;
    int    directed_words;
    int    tape_pos;
    bit    paused;
    string off_side;

    bft_req_if req_ch ();
    bft_rsp_if rsp_ch ();

    bf_tape_datapath_core #(.TAPE_CELLS(TAPE_CELLS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bft_tape_checker #(.TAPE_CELLS(TAPE_CELLS)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Present one word after an optional gap; returns at the edge that takes it
    task automatic send_word(input logic [OP_W-1:0] code, input logic [CNT_W-1:0] cnt,
                             input logic [BYTE_W-1:0] data);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= code;
        req_ch.repeat_count <= cnt;
        req_ch.in_byte      <= data;
        @(negedge i_clk);
        while (!req_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        words_sent++;
    endtask

    // Legal pointer move; the stimulus side tracks the pointer to stay on the tape
    task automatic move_by(input int delta);
        if (delta >= 0)
            send_word(OP_RIGHT, CNT_W'(delta), BYTE_W'($urandom));
        else
            send_word(OP_LEFT, CNT_W'(-delta), BYTE_W'($urandom));
        tape_pos += delta;
    endtask

    // Hold the sender until every owed result is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // One random instruction, weighted toward tape reuse near the pointer
    task automatic random_word();
        int r;
        int target;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            send_word(OP_ADD, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 25) begin
            send_word(OP_SUB, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 45) begin
            if ($urandom_range(0, 15) == 0)
                target = $urandom_range(0, TAPE_CELLS - 1);
            else
                target = tape_pos + int'($urandom_range(0, 16)) - 8;
            if (target < 0) target = 0;
            if (target > TAPE_CELLS - 1) target = TAPE_CELLS - 1;
            move_by(target - tape_pos);
        end else if (r < 53) begin
            send_word(OP_OPEN, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 61) begin
            send_word(OP_CLOSE, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 71) begin
            send_word(OP_OUT, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 81) begin
            send_word(OP_IN, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 87) begin
            send_word(OP_CLEAR, CNT_W'($urandom), BYTE_W'($urandom));
        end else if (r < 92) begin
            send_word(OP_NOP, CNT_W'($urandom), BYTE_W'($urandom));
        end else begin
            send_word(OP_W'($urandom_range(OP_NOP + 1, LAST_CODE)), CNT_W'($urandom),
                      BYTE_W'($urandom));
        end
    endtask

    // A counted loop as a program would run it: [- > + < ] with a random offset and add count
    task automatic run_loop();
        int k;
        int r;
        k = $urandom_range(0, 6);
        r = $urandom_range(1, 4);
        if (tape_pos + r >= TAPE_CELLS) r = -r;
        send_word(OP_IN, CNT_W'($urandom), BYTE_W'(k));
        send_word(OP_OPEN, CNT_W'($urandom), BYTE_W'($urandom));
        repeat (k) begin
            send_word(OP_SUB, CNT_W'(1), BYTE_W'($urandom));
            move_by(r);
            send_word(OP_ADD, CNT_W'($urandom), BYTE_W'($urandom));
            move_by(-r);
            send_word(OP_CLOSE, CNT_W'($urandom), BYTE_W'($urandom));
        end
        send_word(OP_OUT, CNT_W'($urandom), BYTE_W'($urandom));
    endtask

    initial begin
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= OP_NOP;
        req_ch.repeat_count <= '0;
        req_ch.in_byte      <= '0;
        i_rst_n             <= 1'b0;
        calm                <= 1'b0;
        words_sent = 0;
        tape_pos   = 0;
        paused     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero counts, count wrap, bracket tests on zero and nonzero cells
        send_word(OP_ADD, 16'h0000, 8'h00);
        send_word(OP_OPEN, 16'h0000, 8'h00);
        send_word(OP_CLOSE, 16'hFFFF, 8'hFF);
        send_word(OP_ADD, 16'hFFFF, 8'hFF);
        send_word(OP_ADD, 16'h0100, 8'h00);
        send_word(OP_SUB, 16'h0001, 8'h00);
        send_word(OP_SUB, 16'h0000, 8'h00);
        send_word(OP_OUT, 16'h0000, 8'h00);
        send_word(OP_OPEN, 16'h0000, 8'h00);
        send_word(OP_CLOSE, 16'h0000, 8'h00);
        send_word(OP_CLEAR, 16'hFFFF, 8'hFF);
        send_word(OP_OUT, 16'hFFFF, 8'hFF);
        send_word(OP_IN, 16'h0000, 8'hFF);
        send_word(OP_OUT, 16'h0000, 8'h00);
        send_word(OP_IN, 16'hFFFF, 8'h00);
        send_word(OP_IN, 16'h0000, 8'hA5);
        send_word(OP_OUT, 16'h0000, 8'h00);
        // Moves of zero and across the whole tape
        send_word(OP_RIGHT, 16'h0000, 8'h00);
        send_word(OP_LEFT, 16'h0000, 8'h00);
        move_by(TAPE_CELLS - 1);
        send_word(OP_ADD, 16'h00FF, 8'h00);
        send_word(OP_OUT, 16'h0000, 8'h00);
        move_by(-(TAPE_CELLS - 1));
        send_word(OP_OUT, 16'h0000, 8'h00);
        // Nop and unused codes
        send_word(OP_NOP, 16'hFFFF, 8'hFF);
        send_word(LAST_CODE, 16'hFFFF, 8'hFF);
        send_word(OP_W'(OP_NOP + 1), 16'h5555, 8'h55);
        directed_words = words_sent;
        drain();

        // Random: loop sequences and single words, with quiet stretches
        while (words_sent < directed_words + RANDOM_WORDS) begin
            calm <= ((words_sent % 160) < 40);
            if (!paused && words_sent >= directed_words + RANDOM_WORDS / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
                run_loop();
            else
                random_word();
        end

        // Leave the tape on one side, then feed words to the halted block
        if ($urandom_range(0, 1) == 0) begin
            off_side = "left";
            send_word(OP_LEFT, CNT_W'($urandom_range(tape_pos + 1, (1 << CNT_W) - 1)),
                      BYTE_W'($urandom));
        end else begin
            off_side = "right";
            send_word(OP_RIGHT,
                      CNT_W'($urandom_range(TAPE_CELLS - tape_pos, (1 << CNT_W) - 1)),
                      BYTE_W'($urandom));
        end
        repeat (HALT_WORDS)
            send_word(OP_W'($urandom_range(0, LAST_CODE)), CNT_W'($urandom),
                      BYTE_W'($urandom));
        req_ch.valid <= 1'b0;

        // Drain, then allow for any stray late result
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run summary: %0d words sent (%0d directed), %0d results checked.",
                 words_sent, directed_words, results_checked);
        $display("Tape left off the %s end, followed by %0d words to the halted block.",
                 off_side, HALT_WORDS);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
